// ===== src/assert_macros.svh =====
// assertion macros for the table rtl
// no dependencies; included by the files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define OAHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, disabled while reset is asserted
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OAHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define OAHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/oaht_pkg.sv =====
// package for the hash table: field widths, codes and control/status structs
// no dependencies
`default_nettype none

package oaht_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned TAG_W   = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd48;

  // request codes
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // slot tags
  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_FULL  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

  typedef struct packed {
    logic accept;
    logic home_start;
    logic probe_init;
    logic rd_en;
    logic check;
    logic wr_en;
    logic clr_step;
    logic used_clr;
    logic rsp_load;
  } oaht_cmd_t;

  typedef struct packed {
    logic home_done;
    logic in_clear;
    logic in_reject;
    logic probe_end;
    logic clr_last;
    logic out_free;
  } oaht_sts_t;

endpackage

`default_nettype wire

// ===== src/oaht_intf.sv =====
// channel interfaces: request, result and load limit write
// depends on oaht_pkg
`default_nettype none

interface oaht_req_if;
  import oaht_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  key_id;
  logic [HASH_W-1:0] key_hash;
  logic [DATA_W-1:0] set_value;

  modport source (output valid, req_type, key_id, key_hash, set_value, input ready);
  modport sink   (input valid, req_type, key_id, key_hash, set_value, output ready);
endinterface

interface oaht_rsp_if;
  import oaht_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [DATA_W-1:0] read_value;
  logic              status;

  modport source (output valid, hit, read_value, status, input ready);
  modport sink   (input valid, hit, read_value, status, output ready);
endinterface

interface oaht_cfg_if;
  import oaht_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] load_limit;

  modport source (output valid, load_limit, input ready);
  modport sink   (input valid, load_limit, output ready);
endinterface

`default_nettype wire

// ===== src/oaht_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module oaht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/oaht_home.sv =====
// home slot unit: hash modulo capacity, a mask for power-of-two sizes,
// otherwise four remainder steps a cycle; depends on oaht_pkg
`default_nettype none

module oaht_home #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [oaht_pkg::HASH_W-1:0]   hash_i,
  output logic                          done_o,
  output logic [$clog2(CAPACITY)-1:0]   home_o
);
  import oaht_pkg::*;

  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam bit          IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

  generate
    if (IS_POW2) begin : g_pow2
      logic [IDX_W-1:0] home_q;
      logic             done_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          done_q <= 1'b0;
        end else begin
          done_q <= start_i;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          home_q <= hash_i[IDX_W-1:0];
        end
      end

      assign done_o = done_q;
      assign home_o = home_q;
    end else begin : g_div
      localparam int unsigned STEPS  = 4;
      localparam int unsigned CHUNKS = HASH_W / STEPS;
      localparam int unsigned CNT_W  = $clog2(CHUNKS);
      localparam logic [IDX_W:0]      CAP_L   = (IDX_W + 1)'(CAPACITY);
      localparam logic [CNT_W-1:0]    CNT_TOP = CNT_W'(CHUNKS - 1);

      logic [HASH_W-1:0] sh_q;
      logic [IDX_W-1:0]  rem_q, rem_d;
      logic [CNT_W-1:0]  cnt_q;
      logic              busy_q, done_q;

      // restoring remainder, msb first
      always_comb begin
        logic [IDX_W:0] t;
        rem_d = rem_q;
        for (int j = 0; j < STEPS; j++) begin
          t = {rem_d, sh_q[HASH_W-1-j]};
          if (t >= CAP_L) begin
            t = t - CAP_L;
          end
          rem_d = t[IDX_W-1:0];
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          busy_q <= 1'b0;
          done_q <= 1'b0;
          cnt_q  <= '0;
        end else if (start_i) begin
          busy_q <= 1'b1;
          done_q <= 1'b0;
          cnt_q  <= '0;
        end else if (busy_q) begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_TOP) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          done_q <= 1'b0;
        end
      end

      always_ff @(posedge clk_i) begin
        if (start_i) begin
          sh_q  <= hash_i;
          rem_q <= '0;
        end else if (busy_q) begin
          sh_q  <= sh_q << STEPS;
          rem_q <= rem_d;
        end
      end

      assign done_o = done_q;
      assign home_o = rem_q;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== src/oaht_dp.sv =====
// datapath: request latch, slot memory, probe walk, count, limit and result word
// depends on oaht_pkg, oaht_ram and oaht_home
`default_nettype none

module oaht_dp #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  oaht_pkg::oaht_cmd_t              cmd_i,
  output oaht_pkg::oaht_sts_t              sts_o,
  input  logic [oaht_pkg::REQ_W-1:0]       req_type_i,
  input  logic [oaht_pkg::KEY_W-1:0]       key_id_i,
  input  logic [oaht_pkg::HASH_W-1:0]      key_hash_i,
  input  logic [oaht_pkg::DATA_W-1:0]      set_value_i,
  input  logic                             cfg_we_i,
  input  logic [oaht_pkg::LIMIT_W-1:0]     cfg_limit_i,
  output logic                             rsp_valid_o,
  input  logic                             rsp_ready_i,
  output logic                             hit_o,
  output logic [oaht_pkg::DATA_W-1:0]      read_value_o,
  output logic                             status_o
);
  import oaht_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned UCW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = ((UCW > LIMIT_W) ? UCW : LIMIT_W) + 1;
  localparam int unsigned WORD_W = TAG_W + KEY_W + VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [REQ_W-1:0]      type_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [IDX_W-1:0]      idx_q, n_q, tomb_at_q, where_q, clr_idx_q, home;
  logic                  tomb_seen_q, found_q, have_q, fill_q;
  logic [VALUE_BITS-1:0] rd_value_q;
  logic [UCW-1:0]        used_q;
  logic [LIMIT_W-1:0]    limit_q;
  logic                  out_valid_q, hit_q, stat_q;
  logic [DATA_W-1:0]     rval_q;

  logic [WORD_W-1:0]     rdata, wdata;
  logic [TAG_W-1:0]      rtag;
  logic [KEY_W-1:0]      rkey;
  logic [VALUE_BITS-1:0] rval;
  logic                  is_empty, is_tomb, is_match, probe_end, over;
  logic                  need_write, ram_we;
  logic [IDX_W-1:0]      waddr;
  logic                  hit_d, stat_d;
  logic [DATA_W-1:0]     rval_d;

  oaht_home #(.CAPACITY(CAPACITY)) u_home (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.home_start),
    .hash_i  (key_hash_i),
    .done_o  (sts_o.home_done),
    .home_o  (home)
  );

  // slot word: tag | key | value
  oaht_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rtag = rdata[WORD_W-1 -: TAG_W];
  assign rkey = rdata[VALUE_BITS +: KEY_W];
  assign rval = rdata[VALUE_BITS-1:0];

  assign is_empty  = (rtag == TAG_EMPTY);
  assign is_tomb   = (rtag == TAG_TOMB);
  assign is_match  = !is_empty && !is_tomb && (rkey == key_q);
  assign probe_end = is_empty || is_match || (n_q == LAST_IDX);

  assign over = (CMP_W'(used_q) + CMP_W'(1)) > CMP_W'(limit_q);

  assign need_write = ((type_q == REQ_SET) && (found_q || have_q)) ||
                      ((type_q == REQ_DEL) && found_q);
  assign ram_we = (cmd_i.wr_en && need_write) || cmd_i.clr_step;
  assign waddr  = cmd_i.clr_step ? clr_idx_q : where_q;
  assign wdata  = cmd_i.clr_step ? '0 :
                  {((type_q == REQ_SET) ? TAG_FULL : TAG_TOMB), key_q, val_q};

  assign sts_o.in_clear  = (req_type_i == REQ_CLEAR);
  assign sts_o.in_reject = (req_type_i == REQ_SET) && over;
  assign sts_o.probe_end = probe_end;
  assign sts_o.clr_last  = (clr_idx_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  // result word from the latched probe outcome
  always_comb begin
    hit_d  = 1'b0;
    stat_d = 1'b0;
    rval_d = '0;
    case (type_q)
      REQ_GET: begin
        hit_d  = found_q;
        rval_d = found_q ? DATA_W'(rd_value_q) : '0;
      end
      REQ_SET: begin
        hit_d  = !found_q && have_q;
        stat_d = !found_q && !have_q;
      end
      REQ_DEL: begin
        hit_d = found_q;
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      type_q <= req_type_i;
      key_q  <= key_id_i;
      val_q  <= set_value_i[VALUE_BITS-1:0];
    end
    if (cmd_i.check && probe_end) begin
      rd_value_q <= rval;
    end
    if (cmd_i.rsp_load) begin
      hit_q  <= hit_d;
      stat_q <= stat_d;
      rval_q <= rval_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      n_q         <= '0;
      tomb_seen_q <= 1'b0;
      tomb_at_q   <= '0;
      found_q     <= 1'b0;
      have_q      <= 1'b0;
      fill_q      <= 1'b0;
      where_q     <= '0;
    end else if (cmd_i.accept) begin
      found_q <= 1'b0;
      have_q  <= 1'b0;
      fill_q  <= 1'b0;
    end else if (cmd_i.probe_init) begin
      idx_q       <= home;
      n_q         <= '0;
      tomb_seen_q <= 1'b0;
    end else if (cmd_i.check) begin
      if (probe_end) begin
        found_q <= is_match;
        have_q  <= is_match || is_empty || tomb_seen_q || is_tomb;
        fill_q  <= is_empty && !tomb_seen_q;
        if (is_match || !tomb_seen_q) begin
          where_q <= idx_q;
        end else begin
          where_q <= tomb_at_q;
        end
      end else begin
        idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
        n_q   <= n_q + IDX_W'(1);
        if (is_tomb && !tomb_seen_q) begin
          tomb_seen_q <= 1'b1;
          tomb_at_q   <= idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      limit_q     <= LIMIT_RESET;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_limit_i;
      end
      if (cmd_i.used_clr) begin
        used_q <= '0;
      end else if (cmd_i.wr_en && (type_q == REQ_SET) && !found_q && have_q && fill_q) begin
        used_q <= used_q + UCW'(1);
      end
      if (cmd_i.clr_step) begin
        clr_idx_q <= (clr_idx_q == LAST_IDX) ? '0 : clr_idx_q + IDX_W'(1);
      end
      if (cmd_i.rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign status_o     = stat_q;
  assign read_value_o = rval_q;

endmodule

`default_nettype wire

// ===== src/oaht_ctrl.sv =====
// controller: sequences accept, home slot, probe reads, write-back, clear sweep, result
// depends on oaht_pkg
`default_nettype none

module oaht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  oaht_pkg::oaht_sts_t sts_i,
  output oaht_pkg::oaht_cmd_t cmd_o
);
  import oaht_pkg::*;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_HOME  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_clear) begin
            state_d = S_CLEAR;
          end else if (sts_i.in_reject) begin
            state_d = S_DONE;
          end else begin
            cmd_o.home_start = 1'b1;
            state_d          = S_HOME;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.used_clr = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_HOME: begin
        if (sts_i.home_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.probe_end ? S_WRITE : S_READ;
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/open_addressing_hash_table.sv =====
// top level of the open-addressing key/value table
// depends on oaht_pkg, oaht_intf, oaht_ctrl, oaht_dp and assert_macros.svh
//
// linear-probing key/value table with tombstones, CAPACITY slots of one word
// each (tag, 32-bit key identity, VALUE_BITS value) held in a single
// one-read one-write ram. every request word on req_i (get, set, delete or
// clear) gives exactly one result word on rsp_o. the home slot is key_hash
// modulo CAPACITY: a mask when CAPACITY is a power of two, else a remainder
// unit doing four bits a cycle. the probe then visits one slot at a time,
// each by a ram read, then a compare, until a match, an empty slot or the
// last slot of the walk. a set that would pass the load limit is rejected
// without a probe, and a clear sweeps every slot. one request is in flight
// at a time, but the next one is taken while the last result still waits
// in the output register. after reset the ram tags are swept to empty, one
// slot a cycle, before the first request is taken. the load limit (reset
// 48) is written through cfg_i, which is always ready.
`default_nettype none
`include "assert_macros.svh"

module open_addressing_hash_table #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaht_req_if.sink    req_i,
  oaht_rsp_if.source  rsp_o,
  oaht_cfg_if.sink    cfg_i
);
  import oaht_pkg::*;

  oaht_cmd_t cmd;
  oaht_sts_t sts;
  logic      req_ready;

  // control side: owns the state, issues one command group per cycle
  oaht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // data side: slot ram, probe walk, counters and result register
  oaht_dp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_i.req_type),
    .key_id_i     (req_i.key_id),
    .key_hash_i   (req_i.key_hash),
    .set_value_i  (req_i.set_value),
    .cfg_we_i     (cfg_i.valid),
    .cfg_limit_i  (cfg_i.load_limit),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .hit_o        (rsp_o.hit),
    .read_value_o (rsp_o.read_value),
    .status_o     (rsp_o.status)
  );

  assign req_i.ready = req_ready;
  // the limit register takes a write word in any cycle
  assign cfg_i.ready = 1'b1;

  // the block is never ready in the cycle after an accept
  `OAHT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_ready, !req_ready, "request accepted back to back")
  // a result is never loaded over one still waiting
  `OAHT_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.rsp_load, sts.out_free, "result overwritten")
  // a rejected set never reports a hit
  `OAHT_ASSERT_IMPL(a_hit_xor_status, clk_i, rst_ni, rsp_o.valid, !(rsp_o.hit && rsp_o.status), "hit and full status together")
  // the ram has one write port: clear sweep and write-back never overlap
  `OAHT_ASSERT_IMPL(a_one_writer, clk_i, rst_ni, 1'b1, !(cmd.wr_en && cmd.clr_step), "two ram writers")

endmodule

`default_nettype wire

// ===== bench/oaht_checker.sv =====
// result checker for the hash table: watches the request, result and limit channels
// keeps its own copy of the slot table, predicts each result word and compares it
// depends on oaht_pkg and oaht_intf
module oaht_checker #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  oaht_req_if         req_i,
  oaht_rsp_if         rsp_i,
  oaht_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned refused_o,
  output int unsigned found_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import oaht_pkg::*;

  localparam logic [DATA_W-1:0] VALUE_MASK = {DATA_W{1'b1}} >> (DATA_W - VALUE_BITS);

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              status;
  } table_result_t;

  logic [TAG_W-1:0]   slot_tag   [CAPACITY];
  logic [KEY_W-1:0]   slot_key   [CAPACITY];
  logic [DATA_W-1:0]  slot_value [CAPACITY];
  int unsigned        live_slots;
  logic [LIMIT_W-1:0] limit_q;
  table_result_t      expected_results [$];
  int unsigned        fails, checked, refused, found;

  // walk from the home slot; on a miss, where is the first tombstone passed
  // or else the empty slot that ended the walk
  function automatic logic find_key(input logic [KEY_W-1:0] key, input logic [HASH_W-1:0] hash,
                                    output int unsigned where, output logic have);
    int unsigned idx;
    int unsigned tomb_at;
    logic        tomb_seen;
    idx       = hash % CAPACITY;
    tomb_at   = 0;
    tomb_seen = 1'b0;
    for (int unsigned n = 0; n < CAPACITY; n++) begin
      if (slot_tag[idx] == TAG_EMPTY) begin
        where = tomb_seen ? tomb_at : idx;
        have  = 1'b1;
        return 1'b0;
      end
      if (slot_tag[idx] == TAG_TOMB) begin
        if (!tomb_seen) begin
          tomb_seen = 1'b1;
          tomb_at   = idx;
        end
      end else if (slot_key[idx] == key) begin
        where = idx;
        have  = 1'b1;
        return 1'b1;
      end
      idx = (idx + 1) % CAPACITY;
    end
    where = tomb_at;
    have  = tomb_seen;
    return 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int unsigned i = 0; i < CAPACITY; i++) slot_tag[i] = TAG_EMPTY;
    live_slots = 0;
  endfunction

  // apply one request to the table copy and return its result word
  function automatic table_result_t serve_request(input logic [REQ_W-1:0] kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [HASH_W-1:0] hash,
                                                  input logic [DATA_W-1:0] value);
    table_result_t res;
    int unsigned   where;
    logic          have;
    logic          hit_key;
    res   = '0;
    where = 0;
    have  = 1'b0;
    case (kind)
      REQ_GET: begin
        hit_key = find_key(key, hash, where, have);
        if (hit_key) begin
          res.hit        = 1'b1;
          res.read_value = slot_value[where] & VALUE_MASK;
        end
      end
      REQ_SET: begin
        if (live_slots + 1 > limit_q) begin
          res.status = 1'b1;
        end else begin
          hit_key = find_key(key, hash, where, have);
          if (hit_key) begin
            slot_value[where] = value & VALUE_MASK;
          end else if (!have) begin
            res.status = 1'b1;
          end else begin
            res.hit = 1'b1;
            if (slot_tag[where] == TAG_EMPTY) live_slots++;
            slot_tag[where]   = TAG_FULL;
            slot_key[where]   = key;
            slot_value[where] = value & VALUE_MASK;
          end
        end
      end
      REQ_DEL: begin
        hit_key = find_key(key, hash, where, have);
        if (hit_key) begin
          res.hit         = 1'b1;
          slot_tag[where] = TAG_TOMB;
        end
      end
      default: wipe_table();
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    table_result_t want;
    table_result_t got;
    if (!rst_ni) begin
      wipe_table();
      limit_q = LIMIT_RESET;
      expected_results.delete();
      fails   = 0;
      checked = 0;
      refused = 0;
      found   = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) limit_q = cfg_i.load_limit;
      if (rsp_i.valid && rsp_i.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fails++;
        end else begin
          want           = expected_results.pop_front();
          got.hit        = rsp_i.hit;
          got.read_value = rsp_i.read_value;
          got.status     = rsp_i.status;
          if (got.hit !== want.hit) begin
            $error("hit mismatch: expected %0b, got %0b", want.hit, got.hit);
            fails++;
          end
          if (got.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %h, got %h", want.read_value, got.read_value);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0b, got %0b", want.status, got.status);
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = serve_request(req_i.req_type, req_i.key_id, req_i.key_hash, req_i.set_value);
        if (want.status) refused++;
        if (want.hit && req_i.req_type != REQ_SET) found++;
        expected_results.push_back(want);
      end
    end
    fail_count_o  <= fails;
    outstanding_o <= expected_results.size();
    checked_o     <= checked;
    refused_o     <= refused;
    found_o       <= found;
  end

endmodule

// ===== bench/tb_open_addressing_hash_table.sv =====
// testbench top for open_addressing_hash_table: clock, reset, stimulus and verdict
// drives the request and limit channels, stalls the result channel at random
// depends on oaht_pkg, oaht_intf, oaht_checker and the table rtl
module tb_open_addressing_hash_table;
  timeunit 1ns;
  timeprecision 1ps;
  import oaht_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned VALUE_BITS   = 64;
  localparam int unsigned RANDOM_ITEMS = 2000;
  // no word moves for this many cycles: the table is hung
  localparam int unsigned QUIET_LIMIT  = 3000;

  // directed keys; the two hashes share home slot 63 so they collide and wrap
  localparam logic [KEY_W-1:0]  KEY_A    = 32'h0000_1001;
  localparam logic [KEY_W-1:0]  KEY_B    = 32'h0000_2002;
  localparam logic [KEY_W-1:0]  KEY_C    = 32'h0000_3003;
  localparam logic [KEY_W-1:0]  KEY_ZERO = 32'h0000_0000;
  localparam logic [KEY_W-1:0]  KEY_MAX  = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] HASH_63A = 32'h1234_567F;
  localparam logic [HASH_W-1:0] HASH_63B = 32'hABCD_EF3F;
  localparam logic [HASH_W-1:0] HASH_MAX = 32'hFFFF_FFFF;
  localparam logic [HASH_W-1:0] HASH_0   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ONES     = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ZERO     = '0;

  logic clk;
  logic rst_n;
  logic rsp_ready = 1'b0;

  oaht_req_if req_ch ();
  oaht_rsp_if rsp_ch ();
  oaht_cfg_if cfg_ch ();

  assign rsp_ch.ready = rsp_ready;

  int unsigned fail_count, outstanding, checked, refused, found;
  int unsigned total_items, random_items, limit_writes;
  int unsigned quiet_cycles;
  int unsigned stall_left, steady_left;
  logic        steady_tx;

  open_addressing_hash_table #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  oaht_checker #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .refused_o    (refused),
    .found_o      (found)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // value word with the all-zero and all-one corners showing up often
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return ZERO;
    if (r == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  // result side back-pressure, with long stretches of steady ready now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ready   <= 1'b0;
      stall_left  <= 0;
      steady_left <= 0;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if (steady_left != 0) begin
        steady_left <= steady_left - 1;
      end else if ($urandom_range(0, 199) == 0) begin
        steady_left <= $urandom_range(50, 400);
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  // watchdog: any accepted word on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one request word; valid stays high into the next word when there is no gap
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input logic [HASH_W-1:0] hash, input logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = steady_tx ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.key_id    <= key;
    req_ch.key_hash  <= hash;
    req_ch.set_value <= value;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    total_items++;
  endtask

  // drop valid and wait for every result word, then let the table settle
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] limit);
    wait_idle();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.load_limit <= limit;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limit_writes++;
  endtask

  // one stretch of random traffic over a small key set whose home slots
  // crowd into a narrow window, so probe chains, wraps and tombstones build up
  task automatic run_phase(input int unsigned items);
    logic [KEY_W-1:0]  pool_key  [32];
    logic [HASH_W-1:0] pool_hash [32];
    logic [HASH_W-1:0] h;
    logic [REQ_W-1:0]  kind;
    int unsigned       pool_n, base, spread, pick, r;
    pool_n = $urandom_range(4, 32);
    base   = $urandom_range(0, CAPACITY - 1);
    spread = $urandom_range(0, 15);
    for (int unsigned i = 0; i < pool_n; i++) begin
      pool_key[i]  = ($urandom_range(0, 15) == 0) ? KEY_MAX : $urandom;
      h            = $urandom;
      pool_hash[i] = h - (h % CAPACITY) + ((base + $urandom_range(0, spread)) % CAPACITY);
    end
    for (int unsigned i = 0; i < items; i++) begin
      pick = $urandom_range(0, pool_n - 1);
      r    = $urandom_range(0, 99);
      if (r < 96) begin
        if (r < 40)      kind = REQ_SET;
        else if (r < 70) kind = REQ_GET;
        else if (r < 93) kind = REQ_DEL;
        else             kind = REQ_CLEAR;
        send_req(kind, pool_key[pick], pool_hash[pick], pick_value());
      end else begin
        // stray key and hash outside the working set
        case ($urandom_range(0, 2))
          0:       kind = REQ_GET;
          1:       kind = REQ_SET;
          default: kind = REQ_DEL;
        endcase
        send_req(kind, $urandom, $urandom, pick_value());
      end
      random_items++;
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] limit;
    int unsigned        items;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_GET;
    req_ch.key_id     <= '0;
    req_ch.key_hash   <= '0;
    req_ch.set_value  <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.load_limit <= LIMIT_RESET;
    rst_n             <= 1'b0;
    total_items  = 0;
    random_items = 0;
    limit_writes = 0;
    steady_tx    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset limit: misses on an empty table, a collision
    // that wraps from the last slot to slot 0, overwrite, delete and probing
    // past the tombstone, tombstone reuse, key identity zero, the widest key
    send_req(REQ_GET, KEY_A, HASH_63A, ONES);
    send_req(REQ_DEL, KEY_A, HASH_63A, ZERO);
    send_req(REQ_SET, KEY_A, HASH_63A, ONES);
    send_req(REQ_SET, KEY_B, HASH_63B, ZERO);
    send_req(REQ_GET, KEY_B, HASH_63B, ONES);
    send_req(REQ_SET, KEY_A, HASH_63A, 64'h5555_5555_5555_5555);
    send_req(REQ_GET, KEY_A, HASH_63A, ZERO);
    send_req(REQ_DEL, KEY_A, HASH_63A, ZERO);
    send_req(REQ_GET, KEY_B, HASH_63B, ZERO);
    send_req(REQ_GET, KEY_A, HASH_63A, ZERO);
    send_req(REQ_SET, KEY_C, HASH_63B, 64'hAAAA_AAAA_AAAA_AAAA);
    send_req(REQ_SET, KEY_ZERO, HASH_MAX, 64'h0123_4567_89AB_CDEF);
    send_req(REQ_GET, KEY_ZERO, HASH_MAX, ZERO);
    send_req(REQ_SET, KEY_MAX, HASH_0, 64'hFEDC_BA98_7654_3210);
    send_req(REQ_GET, KEY_MAX, HASH_0, ZERO);
    send_req(REQ_DEL, KEY_B, HASH_63B, ONES);
    send_req(REQ_GET, KEY_ZERO, HASH_MAX, ONES);
    send_req(REQ_CLEAR, KEY_MAX, HASH_MAX, ONES);
    send_req(REQ_GET, KEY_C, HASH_63B, ZERO);

    // limit of one: one entry fits, then every set is refused, existing key too
    write_limit(6'd1);
    send_req(REQ_SET, KEY_A, HASH_63A, ONES);
    send_req(REQ_SET, KEY_B, HASH_63B, ONES);
    send_req(REQ_SET, KEY_A, HASH_63A, ZERO);
    send_req(REQ_GET, KEY_A, HASH_63A, ZERO);

    // zero limit refuses every set
    write_limit(6'd0);
    send_req(REQ_SET, KEY_C, HASH_0, ONES);
    send_req(REQ_CLEAR, KEY_A, HASH_63A, ZERO);

    // random phases, each under its own limit; the first one at the top limit
    limit = 6'd63;
    while (random_items < RANDOM_ITEMS) begin
      write_limit(limit);
      steady_tx = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) send_req(REQ_CLEAR, $urandom, $urandom, pick_value());
      items = (limit < 8) ? $urandom_range(20, 60) : $urandom_range(80, 250);
      run_phase(items);
      case ($urandom_range(0, 7))
        0:       limit = 6'd1;
        1, 2:    limit = 6'd63;
        3:       limit = LIMIT_RESET;
        default: limit = LIMIT_W'($urandom_range(2, 62));
      endcase
    end
    steady_tx = 1'b0;

    // drain the last result words, then a margin for anything stray
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d requests (%0d random) over %0d load limit settings",
             total_items, random_items, limit_writes);
    $display("%0d result words checked, %0d sets refused, %0d gets/deletes found their key",
             checked, refused, found);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
